[sv/sab_pkg.sv]
package sab_pkg;

  // Text capacity and number of cells in the sorting ring.
  localparam int unsigned MaxLen   = 64;
  localparam int unsigned NumCells = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned LenW     = 7;
  localparam int unsigned KeyW     = 8;
  localparam int unsigned SfxW     = 7;
  localparam int unsigned NumPass  = 6;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0] suffix_start;
    logic       last_of_run;
    logic       truncated;
  } out_item_t;

  // Operation broadcast to every cell.
  typedef enum logic [2:0] {
    OP_IDLE   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_CSTART = 3'd3,
    OP_COUNT  = 3'd4,
    OP_RANK   = 3'd5,
    OP_SHIFT  = 3'd6,
    OP_ROT    = 3'd7
  } cell_op_e;

  typedef struct packed {
    cell_op_e   op;
    logic [7:0] text_byte;
  } cell_ctrl_t;

  // Sort key that travels around the ring.
  typedef struct packed {
    logic            vld;
    logic [KeyW-1:0] key;
    logic [SfxW-1:0] sfx;
  } circ_t;

endpackage

[sv/sab_cell.sv]
module sab_cell
  import sab_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctrl_t      ctrl_i,
  input  logic            load_en_i,
  input  logic [SfxW-1:0] nbr_sfx_i,
  input  circ_t           nbr_circ_i,
  output logic [SfxW-1:0] sfx_o,
  output circ_t           circ_o
);

  logic            vld_q, vld_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [SfxW-1:0] sfx_q, sfx_d;
  circ_t           circ_q, circ_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            less;

  // The passing key sorts before this cell's own key.
  assign less = circ_q.vld && ({circ_q.key, circ_q.sfx} < {key_q, sfx_q});

  // Next state for each broadcast operation.
  always_comb begin
    vld_d  = vld_q;
    key_d  = key_q;
    sfx_d  = sfx_q;
    circ_d = circ_q;
    cnt_d  = cnt_q;
    case (ctrl_i.op)
      OP_LOAD: begin
        if (load_en_i) begin
          vld_d = 1'b1;
          key_d = ctrl_i.text_byte;
          sfx_d = '0;
        end
      end
      OP_CLEAR: begin
        vld_d = 1'b0;
      end
      OP_CSTART: begin
        circ_d = '{vld: vld_q, key: key_q, sfx: sfx_q};
        cnt_d  = '0;
      end
      OP_COUNT: begin
        if (less) begin
          cnt_d = cnt_q + 1'b1;
        end
        circ_d = nbr_circ_i;
      end
      OP_RANK: begin
        key_d = KeyW'(cnt_q);
        sfx_d = vld_q ? (SfxW'(cnt_q) + 1'b1) : '0;
      end
      OP_SHIFT: begin
        sfx_d = nbr_sfx_i;
      end
      OP_ROT: begin
        circ_d = nbr_circ_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Key data needs no reset.
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    sfx_q  <= sfx_d;
    circ_q <= circ_d;
    cnt_q  <= cnt_d;
  end

  assign sfx_o  = sfx_q;
  assign circ_o = circ_q;

endmodule

[sv/suffix_array_builder_unit.sv]
// Suffix array builder.
// The input channel takes one text byte per item; final_byte marks the last
// byte of a text. Up to 64 bytes are kept, later bytes are dropped and the
// truncated flag is set on every result of that text. After the last byte the
// block sorts all suffixes and gives one result item per stored byte: the
// start positions in ascending suffix order, last_of_run on the final one.
// Loading accepts one byte per cycle. Sorting runs on a ring of 64 cells by
// prefix doubling: seven counting passes with a shift between each pair,
// then the ring rotates to write the rank memory. Each result is then read
// from the rank memory (S_RD) and offered to the receiver (S_OUT).
// The input is not ready while a text is sorted or emitted. A stalled receiver
// holds the current result in place; nothing is lost.
// Reset empties the text store and returns the block to loading.
module suffix_array_builder_unit
  import sab_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  typedef enum logic [8:0] {
    S_LOAD   = 9'b000000001,
    S_CSTART = 9'b000000010,
    S_COUNT  = 9'b000000100,
    S_RANK   = 9'b000001000,
    S_SHIFT  = 9'b000010000,
    S_WSTART = 9'b000100000,
    S_WRITE  = 9'b001000000,
    S_RD     = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;
  logic [IdxW-1:0] cyc_q, cyc_d;
  logic [2:0]      pass_q, pass_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [IdxW-1:0] rd_data_q;
  logic [IdxW-1:0] rank_mem_q [NumCells];
  cell_ctrl_t      ctrl;
  logic            in_acc, out_acc, full, last_res, shift_last;

  logic [SfxW-1:0] sfx_w  [NumCells];
  circ_t           circ_w [NumCells];

  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;
  assign full       = (len_q == LenW'(MaxLen));
  assign last_res   = ((LenW'(rd_idx_q) + 1'b1) == len_q);
  assign shift_last = (LenW'(cyc_q) == ((LenW'(1) << pass_q) - 1'b1));

  // Ring of cells; each takes its neighbor's data.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    logic [SfxW-1:0] nbr_sfx;
    if (k == NumCells - 1) begin : g_end
      assign nbr_sfx = '0;
    end else begin : g_mid
      assign nbr_sfx = sfx_w[k+1];
    end
    sab_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .load_en_i  (len_q == LenW'(k)),
      .nbr_sfx_i  (nbr_sfx),
      .nbr_circ_i (circ_w[(k + 1) % NumCells]),
      .sfx_o      (sfx_w[k]),
      .circ_o     (circ_w[k])
    );
  end

  // Sequencer.
  always_comb begin
    state_d        = state_q;
    len_d          = len_q;
    ovf_d          = ovf_q;
    cyc_d          = cyc_q;
    pass_d         = pass_q;
    rd_idx_d       = rd_idx_q;
    ctrl.op        = OP_IDLE;
    ctrl.text_byte = in_item_i.text_byte;
    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          ctrl.op = OP_LOAD;
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            len_d = len_q + 1'b1;
          end
          if (in_item_i.final_byte) begin
            pass_d  = '0;
            state_d = S_CSTART;
          end
        end
      end
      S_CSTART: begin
        ctrl.op = OP_CSTART;
        cyc_d   = '0;
        state_d = S_COUNT;
      end
      S_COUNT: begin
        ctrl.op = OP_COUNT;
        cyc_d   = cyc_q + 1'b1;
        if (cyc_q == IdxW'(NumCells - 1)) begin
          state_d = S_RANK;
        end
      end
      S_RANK: begin
        ctrl.op = OP_RANK;
        cyc_d   = '0;
        state_d = (pass_q == 3'(NumPass)) ? S_WSTART : S_SHIFT;
      end
      S_SHIFT: begin
        ctrl.op = OP_SHIFT;
        cyc_d   = cyc_q + 1'b1;
        if (shift_last) begin
          pass_d  = pass_q + 1'b1;
          state_d = S_CSTART;
        end
      end
      S_WSTART: begin
        ctrl.op = OP_CSTART;
        cyc_d   = '0;
        state_d = S_WRITE;
      end
      S_WRITE: begin
        ctrl.op = OP_ROT;
        cyc_d   = cyc_q + 1'b1;
        if (cyc_q == IdxW'(NumCells - 1)) begin
          rd_idx_d = '0;
          state_d  = S_RD;
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          if (last_res) begin
            ctrl.op = OP_CLEAR;
            len_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
            state_d  = S_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      len_q    <= '0;
      ovf_q    <= 1'b0;
      cyc_q    <= '0;
      pass_q   <= '0;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      ovf_q    <= ovf_d;
      cyc_q    <= cyc_d;
      pass_q   <= pass_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  // Rank memory: position of each sorted rank, written as the ring rotates.
  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE && circ_w[0].vld) begin
      rank_mem_q[circ_w[0].key[IdxW-1:0]] <= cyc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= rank_mem_q[rd_idx_q];
  end

  assign in_ready_o              = (state_q == S_LOAD);
  assign out_valid_o             = (state_q == S_OUT);
  assign out_item_o.suffix_start = rd_data_q;
  assign out_item_o.last_of_run  = last_res;
  assign out_item_o.truncated    = ovf_q;

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MaxLen)) else $error("text length beyond capacity");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("loading while emitting");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_item_o.last_of_run |=> in_ready_o && len_q == '0)
    else $error("block not back to loading after a run");
`endif

endmodule

[dv/suffix_array_builder_unit_tb.sv]
`timescale 1ns / 1ps

module suffix_array_builder_unit_tb;
  import sab_pkg::*;

  localparam int unsigned Capacity = MaxLen;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  suffix_array_builder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // Free-running clock with a 4 ns period.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Predictor state: the text gathered so far and the overflow flag.
  logic [7:0] text_buf [Capacity];
  int unsigned text_len;
  logic        text_dropped;
  out_item_t   sorted_suffixes [$];

  int unsigned error_count;
  int unsigned items_sent;
  int unsigned texts_sent;
  int unsigned results_seen;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Hand-typed result for the single-item text that is in flight.
  logic      fixed_armed;
  out_item_t fixed_exp;

  // One directed row: the item, and whether a hand-typed result follows it.
  typedef struct {
    in_item_t  item;
    logic      has_fixed;
    out_item_t fixed;
  } directed_row_t;

  directed_row_t directed_rows [$];

  // True when the suffix at p sorts before the suffix at q.
  function automatic logic suffix_before(int unsigned p, int unsigned q, int unsigned n);
    while (p < n && q < n) begin
      if (text_buf[p] != text_buf[q]) return text_buf[p] < text_buf[q];
      p++;
      q++;
    end
    return p >= n && q < n;
  endfunction

  // Store the byte; on the last byte, rank every suffix and queue the results.
  task automatic predict_suffix_order(input in_item_t item);
    int unsigned rank;
    int unsigned order [Capacity];
    out_item_t   res;
    if (text_len < Capacity) begin
      text_buf[text_len] = item.text_byte;
      text_len++;
    end else begin
      text_dropped = 1'b1;
    end
    if (item.final_byte) begin
      for (int unsigned i = 0; i < text_len; i++) begin
        rank = 0;
        for (int unsigned j = 0; j < text_len; j++)
          if (j != i && suffix_before(j, i, text_len)) rank++;
        order[rank] = i;
      end
      for (int unsigned r = 0; r < text_len; r++) begin
        res.suffix_start = order[r][5:0];
        res.last_of_run  = (r + 1 == text_len);
        res.truncated    = text_dropped;
        sorted_suffixes.push_back(res);
      end
      text_len     = 0;
      text_dropped = 1'b0;
      texts_sent++;
    end
  endtask

  // Present one item and hold it until it is accepted. Valid stays high
  // between items unless the sender idles.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{text_byte: b, final_byte: last};
    do @(posedge clk_i); while (!in_ready_o);
    predict_suffix_order('{text_byte: b, final_byte: last});
    items_sent++;
  endtask

  // Stop sending and wait until every queued result has been received.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sorted_suffixes.size() != 0) @(posedge clk_i);
  endtask

  // Random text; mostly short, some longer up to full, a few overflowing.
  task automatic send_random_text();
    int unsigned len;
    int unsigned alpha;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) len = $urandom_range(1, 12);
    else if (pick < 92) len = $urandom_range(13, Capacity);
    else len = $urandom_range(Capacity + 1, Capacity + 4);
    // Small alphabets give long common prefixes.
    alpha = ($urandom_range(1)) ? $urandom_range(1, 3) : 256;
    for (int unsigned k = 0; k < len; k++)
      send_byte((alpha == 256) ? 8'($urandom) : 8'($urandom_range(alpha - 1)),
                k + 1 == len);
  endtask

  // Receiver side: random stalls, compare each result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (fixed_armed) begin
          if (out_item_o.suffix_start !== fixed_exp.suffix_start) begin
            $error("suffix_start: expected %0d, got %0d",
                   fixed_exp.suffix_start, out_item_o.suffix_start);
            error_count++;
          end
          if (out_item_o.last_of_run !== fixed_exp.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b",
                   fixed_exp.last_of_run, out_item_o.last_of_run);
            error_count++;
          end
          if (out_item_o.truncated !== fixed_exp.truncated) begin
            $error("truncated: expected %0b, got %0b",
                   fixed_exp.truncated, out_item_o.truncated);
            error_count++;
          end
          fixed_armed = 1'b0;
        end
        if (sorted_suffixes.size() == 0) begin
          $error("unexpected result: suffix_start %0d", out_item_o.suffix_start);
          error_count++;
        end else begin
          out_item_t exp_res;
          exp_res = sorted_suffixes.pop_front();
          if (out_item_o.suffix_start !== exp_res.suffix_start) begin
            $error("suffix_start: expected %0d, got %0d",
                   exp_res.suffix_start, out_item_o.suffix_start);
            error_count++;
          end
          if (out_item_o.last_of_run !== exp_res.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b",
                   exp_res.last_of_run, out_item_o.last_of_run);
            error_count++;
          end
          if (out_item_o.truncated !== exp_res.truncated) begin
            $error("truncated: expected %0b, got %0b",
                   exp_res.truncated, out_item_o.truncated);
            error_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Overall time limit.
  initial begin
    #40ms;
    $display("suffix_array_builder_unit_tb: errors");
    $finish;
  end

  // Main stimulus.
  initial begin
    error_count    = 0;
    items_sent     = 0;
    texts_sent     = 0;
    results_seen   = 0;
    text_len       = 0;
    text_dropped   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fixed_armed    = 1'b0;
    fixed_exp      = '0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    out_ready_i    = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: single byte after reset (result 0, last, not truncated),
    // extremes, equal bytes and a prefix case.
    directed_rows.push_back('{'{8'h00, 1'b1}, 1'b1, '{6'd0, 1'b1, 1'b0}});
    directed_rows.push_back('{'{8'hFF, 1'b1}, 1'b1, '{6'd0, 1'b1, 1'b0}});
    directed_rows.push_back('{'{8'hFF, 1'b0}, 1'b0, '0});
    directed_rows.push_back('{'{8'h00, 1'b1}, 1'b0, '0});
    directed_rows.push_back('{'{8'h55, 1'b0}, 1'b0, '0});
    directed_rows.push_back('{'{8'h55, 1'b0}, 1'b0, '0});
    directed_rows.push_back('{'{8'h55, 1'b1}, 1'b0, '0});
    directed_rows.push_back('{'{8'hAA, 1'b0}, 1'b0, '0});
    directed_rows.push_back('{'{8'h01, 1'b0}, 1'b0, '0});
    directed_rows.push_back('{'{8'hAA, 1'b0}, 1'b0, '0});
    directed_rows.push_back('{'{8'h01, 1'b1}, 1'b0, '0});
    for (int unsigned i = 0; i < directed_rows.size(); i++) begin
      if (directed_rows[i].has_fixed) begin
        fixed_exp   = directed_rows[i].fixed;
        fixed_armed = 1'b1;
      end
      send_byte(directed_rows[i].item.text_byte, directed_rows[i].item.final_byte);
      wait_drained();
    end
    // Full store, then dropped bytes, the marker on a dropped byte.
    for (int unsigned k = 0; k < Capacity + 2; k++)
      send_byte(8'(k * 37), k == Capacity + 1);
    wait_drained();

    // Random texts across idling phases; now and then a pause for a full drain.
    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      while (items_sent < 100 * (phase + 1)) begin
        send_random_text();
        if ($urandom_range(3) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (700) @(posedge clk_i);
    $display("Sent %0d bytes in %0d texts and checked %0d sorted suffix positions.",
             items_sent, texts_sent, results_seen);
    if (error_count == 0 && sorted_suffixes.size() == 0) begin
      $display("suffix_array_builder_unit_tb: clean");
    end else begin
      $display("suffix_array_builder_unit_tb: errors");
    end
    $finish;
  end

endmodule
